[rtl/core/ett_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ett_pkg
// Shared types and constants for the encoder turn tracker.
// ----------------------------------------------------------------------------
package ett_pkg;

  localparam int RAW_W          = 16;
  localparam int POS_W          = 32;
  localparam int MODE_W         = 2;
  localparam int ANGLE_BITS_DEF = 12;
  localparam int ANGLE_TOP      = 13;

  localparam logic [RAW_W-1:0] ODD_CHECK_MASK  = 16'hAAAA;
  localparam logic [RAW_W-1:0] EVEN_CHECK_MASK = 16'h5555;

  typedef enum logic [MODE_W-1:0] {
    MODE_WORD      = 2'd0,
    MODE_ZERO_CUR  = 2'd1,
    MODE_ZERO_LOAD = 2'd2
  } ett_mode_e;

  typedef struct packed {
    logic      fire;
    ett_mode_e mode;
    logic      word_good;
  } ett_ctrl_t;

endpackage

[rtl/core/ett_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ett_decode
// Parity check of the encoder reply and angle extraction.
// ----------------------------------------------------------------------------
module ett_decode #(
  parameter int ANGLE_BITS = ett_pkg::ANGLE_BITS_DEF
) (
  input  logic                      fire_i,
  input  logic [ett_pkg::MODE_W-1:0] mode_i,
  input  logic                      word_arrived_i,
  input  logic [ett_pkg::RAW_W-1:0] raw_word_i,
  output ett_pkg::ett_ctrl_t        ctrl_o,
  output logic [ANGLE_BITS-1:0]     angle_o
);
  import ett_pkg::*;

  logic odd_ok;
  logic even_ok;

  // odd parity over the odd-position bits and over the even-position bits, check bit included
  assign odd_ok  = ^(raw_word_i & ODD_CHECK_MASK);
  assign even_ok = ^(raw_word_i & EVEN_CHECK_MASK);

  assign ctrl_o.fire      = fire_i;
  assign ctrl_o.mode      = ett_mode_e'(mode_i);
  assign ctrl_o.word_good = word_arrived_i & odd_ok & even_ok;

  assign angle_o = raw_word_i[ANGLE_TOP : ANGLE_TOP+1-ANGLE_BITS];

endmodule

[rtl/core/ett_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ett_track
// Turn unwrap, count accumulation, zero offset and position state.
// ----------------------------------------------------------------------------
module ett_track #(
  parameter int ANGLE_BITS = ett_pkg::ANGLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ett_pkg::ett_ctrl_t        ctrl_i,
  input  logic [ANGLE_BITS-1:0]     angle_i,
  input  logic [ett_pkg::POS_W-1:0] zero_value_i,
  output logic                      ok_d_o,
  output logic [ett_pkg::POS_W-1:0] position_d_o,
  output logic [ett_pkg::POS_W-1:0] last_position_o
);
  import ett_pkg::*;

  localparam int DW = ANGLE_BITS + 2;
  localparam logic signed [DW-1:0] HalfTurn  = DW'(1) << (ANGLE_BITS - 1);
  localparam logic signed [DW-1:0] TurnUnits = DW'(1) << ANGLE_BITS;

  logic [POS_W-1:0]      turn_count_q, turn_count_d;
  logic [ANGLE_BITS-1:0] last_angle_q, last_angle_d;
  logic [POS_W-1:0]      zero_offset_q, zero_offset_d;
  logic [POS_W-1:0]      last_pos_q, last_pos_d;

  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] delta;
  logic [POS_W-1:0]     delta_ext;
  logic [POS_W-1:0]     count_upd;
  logic                 take_word;

  assign diff = $signed({2'b00, angle_i}) - $signed({2'b00, last_angle_q});

  always_comb begin
    if (diff > HalfTurn) begin
      delta = diff - TurnUnits;
    end else if (diff < -HalfTurn) begin
      delta = diff + TurnUnits;
    end else begin
      delta = diff;
    end
  end

  assign delta_ext = {{(POS_W-DW){delta[DW-1]}}, delta};
  assign count_upd = turn_count_q + delta_ext;
  assign take_word = ctrl_i.fire && (ctrl_i.mode == MODE_WORD) && ctrl_i.word_good;

  always_comb begin
    turn_count_d  = turn_count_q;
    last_angle_d  = last_angle_q;
    zero_offset_d = zero_offset_q;
    last_pos_d    = last_pos_q;
    if (ctrl_i.fire) begin
      case (ctrl_i.mode)
        MODE_WORD: begin
          if (ctrl_i.word_good) begin
            turn_count_d = count_upd;
            last_angle_d = angle_i;
            last_pos_d   = zero_offset_q - count_upd;
          end
        end
        MODE_ZERO_CUR:  zero_offset_d = turn_count_q;
        MODE_ZERO_LOAD: zero_offset_d = zero_value_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_count_q  <= '0;
      last_angle_q  <= '0;
      zero_offset_q <= '0;
      last_pos_q    <= '0;
    end else begin
      turn_count_q  <= turn_count_d;
      last_angle_q  <= last_angle_d;
      zero_offset_q <= zero_offset_d;
      last_pos_q    <= last_pos_d;
    end
  end

  assign ok_d_o          = take_word;
  assign position_d_o    = last_pos_d;
  assign last_position_o = last_pos_q;

endmodule

[rtl/core/encoder_turn_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_turn_tracker_unit
// Multi-turn position tracker for a 16-bit absolute encoder reply.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with mode, word_arrived, raw_word
// and zero_value. Mode 0 is an encoder reply, mode 1 takes the present count
// as zero, mode 2 loads zero_value as the offset; mode 3 is ignored.
// Output channel: out_valid_o / out_stall_i with ok and position. Every input
// word yields exactly one output word.
// A word is registered on entry, processed by the parity check, unwrap and
// accumulate logic, and written into the output register that drives
// out_valid_o. One word is taken per cycle while the output side keeps up;
// the rate is set by the single accumulate path through the turn count
// register.
// Reset clears the count, last angle, zero offset and position to zero and
// empties both registers. While the receiver stalls, the output word holds;
// the input register still fills, and in_stall_o rises once both are full.
// ----------------------------------------------------------------------------
module encoder_turn_tracker_unit #(
  parameter int ANGLE_BITS = ett_pkg::ANGLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ett_pkg::MODE_W-1:0] mode_i,
  input  logic                       word_arrived_i,
  input  logic [ett_pkg::RAW_W-1:0]  raw_word_i,
  input  logic signed [ett_pkg::POS_W-1:0] zero_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic signed [ett_pkg::POS_W-1:0] position_o
);
  import ett_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [MODE_W-1:0] mode_q;
  logic              arrived_q;
  logic [RAW_W-1:0]  raw_q;
  logic [POS_W-1:0]  zval_q;

  logic              out_valid_q, out_valid_d;
  logic              ok_q;
  logic [POS_W-1:0]  pos_q;

  logic                  advance;
  logic                  accept;
  ett_ctrl_t             ctrl;
  logic [ANGLE_BITS-1:0] angle;
  logic                  ok_d;
  logic [POS_W-1:0]      pos_d;
  logic [POS_W-1:0]      last_pos;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_stall_o ? in_valid_q : in_valid_i;
  assign out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      arrived_q <= word_arrived_i;
      raw_q     <= raw_word_i;
      zval_q    <= zero_value_i;
    end
    if (advance) begin
      ok_q  <= ok_d;
      pos_q <= pos_d;
    end
  end

  ett_decode #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_decode (
    .fire_i         (advance),
    .mode_i         (mode_q),
    .word_arrived_i (arrived_q),
    .raw_word_i     (raw_q),
    .ctrl_o         (ctrl),
    .angle_o        (angle)
  );

  ett_track #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .angle_i         (angle),
    .zero_value_i    (zval_q),
    .ok_d_o          (ok_d),
    .position_d_o    (pos_d),
    .last_position_o (last_pos)
  );

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign position_o  = $signed(pos_q);

  // held output word always mirrors the tracked position
  a_pos_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pos_q == last_pos))
    else $error("output position differs from tracked position");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_valid_q)
    else $error("accepted word not held in input register");

  a_ok_only_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ok_d) |-> (ctrl.mode == MODE_WORD && ctrl.word_good))
    else $error("ok raised for a non-word item");

endmodule
